@@ hw/rtl/truth_table_gate_network_evaluator_unit_macros.svh @@
// Assertion macros used by the top level of the truth table evaluator RTL.
`ifndef TRUTH_TABLE_GATE_NETWORK_EVALUATOR_UNIT_MACROS_SVH
`define TRUTH_TABLE_GATE_NETWORK_EVALUATOR_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// Checks a property on every rising edge of clk outside reset.
`define TTGNE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Checks that the consequent holds in the same cycle as the antecedent.
`define TTGNE_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define TTGNE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define TTGNE_ASSERT(label, prop, msg)
`define TTGNE_ASSERT_IMPL(label, ante, cons, msg)
`define TTGNE_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

@@ hw/rtl/ttgne_pkg.sv @@
// Package with the types, constants and helper functions of the truth table evaluator.
`timescale 1ns / 1ps
`default_nettype none

package ttgne_pkg;

	localparam int TT_W         = 64;
	localparam int SLOT_W       = 8;
	localparam int VAR_W        = 3;
	localparam int OP_W         = 4;
	localparam int COUNT_W      = 3;
	localparam int FANIN_FIELDS = 4;
	localparam int LANE_W       = 2;

	// Gate kinds as carried by the operation field.
	localparam logic [OP_W-1:0] OP_ZERO = 4'd0;
	localparam logic [OP_W-1:0] OP_ONE  = 4'd1;
	localparam logic [OP_W-1:0] OP_NOP  = 4'd2;
	localparam logic [OP_W-1:0] OP_IN   = 4'd3;
	localparam logic [OP_W-1:0] OP_OUT  = 4'd4;
	localparam logic [OP_W-1:0] OP_NOT  = 4'd5;
	localparam logic [OP_W-1:0] OP_AND  = 4'd6;
	localparam logic [OP_W-1:0] OP_OR   = 4'd7;
	localparam logic [OP_W-1:0] OP_XOR  = 4'd8;
	localparam logic [OP_W-1:0] OP_NAND = 4'd9;
	localparam logic [OP_W-1:0] OP_NOR  = 4'd10;
	localparam logic [OP_W-1:0] OP_XNOR = 4'd11;
	localparam logic [OP_W-1:0] OP_MAJ  = 4'd12;

	localparam logic [COUNT_W-1:0] MAJ_ARITY = 3'd3;

	typedef struct packed {
		logic [OP_W-1:0]    operation;
		logic               is_source;
		logic [VAR_W-1:0]   var_index;
		logic [SLOT_W-1:0]  gate_slot;
		logic [COUNT_W-1:0] fanin_count;
		logic [SLOT_W-1:0]  fanin_a;
		logic [SLOT_W-1:0]  fanin_b;
		logic [SLOT_W-1:0]  fanin_c;
		logic [SLOT_W-1:0]  fanin_d;
		logic               is_target;
	} gate_item_t;

	typedef struct packed {
		logic [TT_W-1:0] gate_table;
		logic            target_flag;
	} gate_result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_CALC
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              load;
		logic              rd_en;
		logic              rd_from_in;
		logic [LANE_W-1:0] rd_lane;
		logic              calc;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [COUNT_W-1:0] in_count;
		logic [COUNT_W-1:0] item_count;
		logic               out_free;
		logic               capture_pending;
	} ctrl_sts_t;

	// Projection pattern of one of the six variables; higher numbers give zero.
	function automatic logic [TT_W-1:0] var_pattern(input logic [VAR_W-1:0] var_num);
		logic [TT_W-1:0] pat;
		case (var_num)
			3'd0:    pat = 64'hAAAA_AAAA_AAAA_AAAA;
			3'd1:    pat = 64'hCCCC_CCCC_CCCC_CCCC;
			3'd2:    pat = 64'hF0F0_F0F0_F0F0_F0F0;
			3'd3:    pat = 64'hFF00_FF00_FF00_FF00;
			3'd4:    pat = 64'hFFFF_0000_FFFF_0000;
			3'd5:    pat = 64'hFFFF_FFFF_0000_0000;
			default: pat = '0;
		endcase
		return pat;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ttgne_word_if.sv @@
// Valid/ready channel interface that carries one word per handshake.
`timescale 1ns / 1ps
`default_nettype none

interface ttgne_word_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ttgne_ctrl.sv @@
// Controller state machine that sequences fanin reads, the gate evaluation and the store write.
`timescale 1ns / 1ps
`default_nettype none

module ttgne_ctrl
	import ttgne_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire ctrl_sts_t sts,
	output ctrl_cmd_t      cmd
);

	ctrl_state_t       state_q;
	ctrl_state_t       state_next;
	logic [LANE_W-1:0] lane_q;
	logic [LANE_W-1:0] lane_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lane_q  <= '0;
		end else begin
			state_q <= state_next;
			lane_q  <= lane_next;
		end
	end

	always_comb begin
		state_next     = state_q;
		lane_next      = lane_q;
		in_ready       = 1'b0;
		cmd            = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (sts.in_count == '0) begin
						state_next = ST_CALC;
					end else begin
						// The first fanin is read straight from the incoming word.
						cmd.rd_en      = 1'b1;
						cmd.rd_from_in = 1'b1;
						lane_next      = LANE_W'(1);
						state_next     = (sts.in_count == COUNT_W'(1)) ? ST_DRAIN : ST_READ;
					end
				end
			end
			ST_READ: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_lane = lane_q;
				lane_next   = lane_q + LANE_W'(1);
				if ((COUNT_W'(lane_q) + COUNT_W'(1)) == sts.item_count) begin
					state_next = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_next = ST_CALC;
			end
			ST_CALC: begin
				if (sts.out_free) begin
					cmd.calc   = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ hw/rtl/ttgne_datapath.sv @@
// Datapath with the table store, fanin operand lanes, gate logic and the output register.
`timescale 1ns / 1ps
`default_nettype none

module ttgne_datapath
	import ttgne_pkg::*;
#(
	parameter int NUM_GATES = 256,
	parameter int MAX_FANIN = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire gate_item_t   in_item,
	input  wire ctrl_cmd_t    cmd,
	output ctrl_sts_t         sts,
	input  wire logic         out_ready,
	output logic              out_valid,
	output gate_result_t      out_item
);

	localparam int AW        = $clog2(NUM_GATES);
	localparam int RW        = AW + 4;
	localparam int LIMIT_INT = (MAX_FANIN < FANIN_FIELDS) ? MAX_FANIN : FANIN_FIELDS;
	localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(LIMIT_INT);

	// Slot numbers are below 256 and the store has at least 16 entries, so the
	// quotient fits in four bits and four conditional subtractions reduce it.
	function automatic logic [AW-1:0] slot_index(input logic [SLOT_W-1:0] slot);
		logic [RW-1:0] rem;
		rem = RW'(slot);
		for (int k = 3; k >= 0; k--) begin
			if (rem >= (RW'(NUM_GATES) << k)) begin
				rem = rem - (RW'(NUM_GATES) << k);
			end
		end
		return rem[AW-1:0];
	endfunction

	function automatic logic [COUNT_W-1:0] sat_count(input logic [COUNT_W-1:0] cnt);
		return (cnt > COUNT_LIMIT) ? COUNT_LIMIT : cnt;
	endfunction

	logic [TT_W-1:0]    store_mem [NUM_GATES];
	logic [TT_W-1:0]    rdata_q;
	gate_item_t         item_q;
	logic               rd_vld_s1;
	logic [LANE_W-1:0]  rd_lane_s1;
	logic [TT_W-1:0]    op_q [FANIN_FIELDS];
	logic [TT_W-1:0]    gate_table_q;
	logic               target_q;
	logic               out_valid_q;
	logic [SLOT_W-1:0]  rd_slot;
	logic [AW-1:0]      rd_addr;
	logic [AW-1:0]      wr_addr;
	logic [COUNT_W-1:0] item_count;
	logic [TT_W-1:0]    result;

	assign item_count = sat_count(item_q.fanin_count);

	always_comb begin
		if (cmd.rd_from_in) begin
			rd_slot = in_item.fanin_a;
		end else begin
			case (cmd.rd_lane)
				2'd0:    rd_slot = item_q.fanin_a;
				2'd1:    rd_slot = item_q.fanin_b;
				2'd2:    rd_slot = item_q.fanin_c;
				default: rd_slot = item_q.fanin_d;
			endcase
		end
	end

	assign rd_addr = slot_index(rd_slot);
	assign wr_addr = slot_index(item_q.gate_slot);

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			store_mem[wr_addr] <= result;
		end
		if (cmd.rd_en) begin
			rdata_q <= store_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_item;
		end
		if (rd_vld_s1) begin
			op_q[rd_lane_s1] <= rdata_q;
		end
		if (cmd.calc) begin
			gate_table_q <= result;
			target_q     <= item_q.is_target;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1   <= 1'b0;
			rd_lane_s1  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1  <= cmd.rd_en;
			rd_lane_s1 <= cmd.rd_from_in ? '0 : cmd.rd_lane;
			if (cmd.calc) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Gate evaluation over the captured operands; lanes past the count read as zero.
	always_comb begin
		logic [TT_W-1:0] opm [FANIN_FIELDS];
		logic [TT_W-1:0] and_acc;
		logic [TT_W-1:0] or_acc;
		logic [TT_W-1:0] xor_acc;
		logic [TT_W-1:0] maj;
		for (int i = 0; i < FANIN_FIELDS; i++) begin
			opm[i] = (COUNT_W'(i) < item_count) ? op_q[i] : '0;
		end
		and_acc = opm[0];
		or_acc  = opm[0];
		xor_acc = opm[0];
		for (int i = 1; i < FANIN_FIELDS; i++) begin
			if (COUNT_W'(i) < item_count) begin
				and_acc = and_acc & opm[i];
				or_acc  = or_acc | opm[i];
				xor_acc = xor_acc ^ opm[i];
			end
		end
		maj = (opm[0] & opm[1]) | (opm[0] & opm[2]) | (opm[1] & opm[2]);
		if (item_q.is_source) begin
			result = var_pattern(item_q.var_index);
		end else begin
			case (item_q.operation)
				OP_ZERO: result = '0;
				OP_ONE:  result = '1;
				OP_NOP:  result = opm[0];
				OP_IN:   result = opm[0];
				OP_OUT:  result = opm[0];
				OP_NOT:  result = ~opm[0];
				OP_AND:  result = and_acc;
				OP_OR:   result = or_acc;
				OP_XOR:  result = xor_acc;
				OP_NAND: result = ~and_acc;
				OP_NOR:  result = ~or_acc;
				OP_XNOR: result = ~xor_acc;
				OP_MAJ:  result = (item_count == MAJ_ARITY) ? maj : '0;
				default: result = '0;
			endcase
		end
	end

	assign sts.in_count        = sat_count(in_item.fanin_count);
	assign sts.item_count      = item_count;
	assign sts.out_free        = !out_valid_q || out_ready;
	assign sts.capture_pending = rd_vld_s1;

	assign out_valid            = out_valid_q;
	assign out_item.gate_table  = gate_table_q;
	assign out_item.target_flag = target_q;

endmodule

`default_nettype wire

@@ hw/rtl/truth_table_gate_network_evaluator_unit.sv @@
// Top level of the six-variable truth table gate network evaluator.
//
//  channel    direction  word           fields
//  gate_in    sink       gate_item_t    operation, is_source, var_index, gate_slot,
//                                       fanin_count, fanin_a..fanin_d, is_target
//  table_out  source     gate_result_t  gate_table, target_flag
//
// A gate with n fanins (n saturated to the smaller of MAX_FANIN and four) is accepted in
// IDLE, reads its second and later fanins in READ, passes DRAIN when n is not zero and
// reaches its result register in CALC; only then is the sequencer idle again. The single
// read port of the table store paces READ: one fanin table is read per cycle, and the
// last one is captured in the cycle after its read.
// Reset clears the control state only; the table store holds no defined contents until
// each slot is written. A stalled table_out holds the evaluation in its final cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "truth_table_gate_network_evaluator_unit_macros.svh"

module truth_table_gate_network_evaluator_unit
	import ttgne_pkg::*;
#(
	parameter int NUM_GATES = 256,
	parameter int MAX_FANIN = 4
) (
	input wire logic       clk,
	input wire logic       arst_n,
	ttgne_word_if.sink     gate_in,
	ttgne_word_if.source   table_out
);

	// Command and status bundles between the sequencer and the datapath.
	ctrl_cmd_t    cmd;
	ctrl_sts_t    sts;
	gate_item_t   in_item;
	gate_result_t out_item;

	assign in_item = gate_in.data;

	// The sequencer accepts a gate word only when idle, then walks the fanin
	// lanes one store read per cycle, waits for the last read to land, and
	// finally evaluates the gate, writing the store and the output register
	// in the same cycle. The output register frees the input side: a new gate
	// word can be taken while the previous result still waits on table_out.
	ttgne_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (gate_in.valid),
		.in_ready (gate_in.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath owns the table store, the captured gate word, the operand
	// lanes and the gate logic. Fanins are read before the gate's own slot is
	// written, so a gate naming its own slot sees the previous table there.
	ttgne_datapath #(
		.NUM_GATES (NUM_GATES),
		.MAX_FANIN (MAX_FANIN)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (table_out.ready),
		.out_valid (table_out.valid),
		.out_item  (out_item)
	);

	assign table_out.data = out_item;

	// Every fanin read must have landed in its lane before the gate is evaluated.
	`TTGNE_ASSERT_IMPL(a_calc_after_capture, cmd.calc, !sts.capture_pending, "gate evaluated with a fanin read in flight")

	// Reading and writing the store never share a cycle.
	`TTGNE_ASSERT(a_no_read_on_write, !(cmd.rd_en && cmd.calc), "store read and write in the same cycle")

	// An evaluation always presents its result on the next cycle.
	`TTGNE_ASSERT_NEXT(a_result_follows_calc, cmd.calc, table_out.valid, "evaluated table not presented")

	// Only one gate word is in work at a time.
	`TTGNE_ASSERT_NEXT(a_busy_after_accept, gate_in.valid && gate_in.ready, !gate_in.ready, "input still ready after accepting a gate word")

endmodule

`default_nettype wire
